### rtl/core/lwsf_pkg.sv
// Shared types, constants and helpers for the LED waterfall stack-fill engine.
package lwsf_pkg;

    localparam int LED_COUNT_W      = 7;
    localparam int LED_COUNT_RESET  = 64;
    localparam int MAX_LEDS_DEFAULT = 64;
    localparam int MS_W             = 16;
    localparam int COLOR_W          = 8;
    localparam int RGB_W            = 3 * COLOR_W;
    localparam int IDX_W            = 6;
    localparam int ACC_W            = 17;
    localparam int CMD_DEPTH        = 2;
    localparam int RES_DEPTH        = 2;

    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

    typedef enum logic
    {
        OP_RESTART = 1'b0,
        OP_TICK    = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        FS_IDLE,
        FS_DIVIDE,
        FS_ISSUE
    } front_state_t;

    typedef enum logic [1:0]
    {
        BS_IDLE,
        BS_CLEAR,
        BS_MOVE
    } back_state_t;

    typedef struct packed
    {
        op_t                    op;
        logic [MS_W-1:0]        elapsed;
        logic [MS_W-1:0]        step_time;
        logic [RGB_W-1:0]       rgb;
    } cmd_t;

    typedef struct packed
    {
        logic [IDX_W-1:0]       led_index;
        logic [RGB_W-1:0]       rgb;
        logic                   finished;
        logic                   is_last;
    } res_t;

    function automatic int clamp_count(input logic [LED_COUNT_W-1:0] value, input int max_leds);
        int n;
        begin
            n = int'(value);
            if (n < 2)
            begin
                n = 2;
            end
            if (n > max_leds)
            begin
                n = max_leds;
            end
            return n;
        end
    endfunction

endpackage

### rtl/core/lwsf_fifo.sv
// Small register queue with fill count, used between stages.
module lwsf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]  mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              do_wr;
    logic              do_rd;

    assign full    = (fill_reg == FILL_W'(DEPTH));
    assign empty   = (fill_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### rtl/core/lwsf_div.sv
// Restoring serial divider, one quotient bit per cycle.
module lwsf_div #(
    parameter int DIVIDEND_W = 16,
    parameter int DIVISOR_W  = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  rem_next;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVIDEND_W-1:0] quo_next;
    logic [DIVISOR_W-1:0]  div_reg;
    logic [DIVISOR_W-1:0]  div_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic                  busy_reg;
    logic                  busy_next;
    logic                  done_reg;
    logic                  done_next;
    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;
    logic                  ge;

    assign shifted  = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign ge       = (shifted >= {1'b0, div_reg});
    assign diff     = shifted - {1'b0, div_reg};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], ge};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DIVIDEND_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

endmodule

### rtl/core/lwsf_front.sv
// Front end: accept requests, latch LED count, work out the step time of each tick.
module lwsf_front #(
    parameter int MAX_LEDS = lwsf_pkg::MAX_LEDS_DEFAULT,
    parameter int CNT_W    = $clog2(MAX_LEDS + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [lwsf_pkg::LED_COUNT_W-1:0]    cfg_data,
    input  logic                                push,
    output logic                                full,
    input  logic                                operation,
    input  logic [lwsf_pkg::MS_W-1:0]           delta_ms,
    input  logic [lwsf_pkg::MS_W-1:0]           period_ms,
    input  logic [lwsf_pkg::RGB_W-1:0]          rgb,
    output logic                                cmd_push,
    input  logic                                cmd_full,
    output lwsf_pkg::cmd_t                      cmd,
    output logic [CNT_W-1:0]                    cmd_count
);

    localparam int RESET_N     = (lwsf_pkg::LED_COUNT_RESET > MAX_LEDS) ?
                                 MAX_LEDS : lwsf_pkg::LED_COUNT_RESET;
    localparam int MAX_TOTAL   = MAX_LEDS * (MAX_LEDS + 1) / 2;
    localparam int TOT_W       = $clog2(MAX_TOTAL + 1);
    localparam int PROD_W      = TOT_W + 1;
    localparam int RESET_TOTAL = RESET_N * (RESET_N + 1) / 2;

    lwsf_pkg::front_state_t            state_reg;
    lwsf_pkg::front_state_t            state_next;
    logic [lwsf_pkg::LED_COUNT_W-1:0]  led_count_reg;
    logic [CNT_W-1:0]                  count_reg;
    logic [CNT_W-1:0]                  count_next;
    logic [TOT_W-1:0]                  total_reg;
    logic [TOT_W-1:0]                  total_next;
    lwsf_pkg::op_t                     op_reg;
    logic [lwsf_pkg::MS_W-1:0]         elapsed_reg;
    logic [lwsf_pkg::RGB_W-1:0]        rgb_reg;
    logic                              accept;
    logic                              div_start;
    logic                              div_done;
    logic [lwsf_pkg::MS_W-1:0]         quotient;
    logic [PROD_W-1:0]                 n_ext;
    logic [PROD_W-1:0]                 prod;

    assign full      = (state_reg != lwsf_pkg::FS_IDLE);
    assign accept    = push && (state_reg == lwsf_pkg::FS_IDLE);
    assign div_start = accept && (lwsf_pkg::op_t'(operation) == lwsf_pkg::OP_TICK);

    assign n_ext = PROD_W'(lwsf_pkg::clamp_count(led_count_reg, MAX_LEDS));
    assign prod  = n_ext * (n_ext + PROD_W'(1));

    assign cmd.op        = op_reg;
    assign cmd.elapsed   = elapsed_reg;
    assign cmd.step_time = quotient;
    assign cmd.rgb       = rgb_reg;
    assign cmd_count     = count_reg;

    lwsf_div #(
        .DIVIDEND_W (lwsf_pkg::MS_W),
        .DIVISOR_W  (TOT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (period_ms),
        .divisor  (total_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        total_next = total_reg;
        cmd_push   = 1'b0;
        case (state_reg)
            lwsf_pkg::FS_IDLE:
            begin
                if (push)
                begin
                    if (lwsf_pkg::op_t'(operation) == lwsf_pkg::OP_RESTART)
                    begin
                        count_next = CNT_W'(n_ext);
                        total_next = prod[PROD_W-1:1];
                        state_next = lwsf_pkg::FS_ISSUE;
                    end
                    else
                    begin
                        state_next = lwsf_pkg::FS_DIVIDE;
                    end
                end
            end
            lwsf_pkg::FS_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = lwsf_pkg::FS_ISSUE;
                end
            end
            lwsf_pkg::FS_ISSUE:
            begin
                if (!cmd_full)
                begin
                    cmd_push   = 1'b1;
                    state_next = lwsf_pkg::FS_IDLE;
                end
            end
            default:
            begin
                state_next = lwsf_pkg::FS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lwsf_pkg::FS_IDLE;
            led_count_reg <= lwsf_pkg::LED_COUNT_W'(lwsf_pkg::LED_COUNT_RESET);
            count_reg     <= CNT_W'(RESET_N);
            total_reg     <= TOT_W'(RESET_TOTAL);
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            total_reg <= total_next;
            if (cfg_write)
            begin
                led_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= lwsf_pkg::op_t'(operation);
            elapsed_reg <= delta_ms;
            rgb_reg     <= rgb;
        end
    end

    chk_div_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == lwsf_pkg::FS_DIVIDE))
        else $error("divider finished outside divide state");

    chk_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CNT_W'(2)) && (count_reg <= CNT_W'(MAX_LEDS)))
        else $error("latched LED count out of range");

endmodule

### rtl/core/lwsf_back.sv
// Back end: hold the pattern state and issue LED writes for each request.
module lwsf_back #(
    parameter int MAX_LEDS = lwsf_pkg::MAX_LEDS_DEFAULT,
    parameter int CNT_W    = $clog2(MAX_LEDS + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_empty,
    input  lwsf_pkg::cmd_t     cmd,
    input  logic [CNT_W-1:0]   cmd_count,
    output logic               cmd_pop,
    input  logic               res_full,
    output logic               res_push,
    output lwsf_pkg::res_t     res
);

    localparam int RESET_N = (lwsf_pkg::LED_COUNT_RESET > MAX_LEDS) ?
                             MAX_LEDS : lwsf_pkg::LED_COUNT_RESET;
    localparam int ACC_W   = lwsf_pkg::ACC_W;

    lwsf_pkg::back_state_t         state_reg;
    lwsf_pkg::back_state_t         state_next;
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic [ACC_W-1:0]              acc_reg;
    logic [ACC_W-1:0]              acc_next;
    logic [CNT_W-1:0]              rows_reg;
    logic [CNT_W-1:0]              rows_next;
    logic [CNT_W-1:0]              fall_reg;
    logic [CNT_W-1:0]              fall_next;
    logic [lwsf_pkg::RGB_W-1:0]    drop_reg;
    logic [lwsf_pkg::RGB_W-1:0]    drop_next;
    logic                          done_reg;
    logic                          done_next;
    logic [CNT_W-1:0]              idx_reg;
    logic [CNT_W-1:0]              idx_next;
    logic [ACC_W:0]                acc_sum;
    logic [ACC_W-1:0]              acc_sat;
    logic [CNT_W-1:0]              fall_inc;
    logic                          clear_last;

    assign acc_sum    = {1'b0, acc_reg} + (ACC_W + 1)'(cmd.elapsed);
    assign acc_sat    = acc_sum[ACC_W] ? lwsf_pkg::ACC_MAX : acc_sum[ACC_W-1:0];
    assign fall_inc   = fall_reg + CNT_W'(1);
    assign clear_last = (idx_reg == count_reg - CNT_W'(1));

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        acc_next   = acc_reg;
        rows_next  = rows_reg;
        fall_next  = fall_reg;
        drop_next  = drop_reg;
        done_next  = done_reg;
        idx_next   = idx_reg;
        cmd_pop    = 1'b0;
        res_push   = 1'b0;
        res        = '0;
        case (state_reg)
            lwsf_pkg::BS_IDLE:
            begin
                if (!cmd_empty && !res_full)
                begin
                    cmd_pop = 1'b1;
                    if (cmd.op == lwsf_pkg::OP_RESTART)
                    begin
                        count_next = cmd_count;
                        acc_next   = '0;
                        rows_next  = cmd_count - CNT_W'(1);
                        fall_next  = CNT_W'(1);
                        drop_next  = cmd.rgb;
                        done_next  = 1'b0;
                        idx_next   = '0;
                        state_next = lwsf_pkg::BS_CLEAR;
                    end
                    else if (!done_reg)
                    begin
                        if (acc_sat < ACC_W'(cmd.step_time))
                        begin
                            acc_next = acc_sat;
                        end
                        else
                        begin
                            acc_next = '0;
                            res_push = 1'b1;
                            if (fall_reg == '0)
                            begin
                                res.led_index = lwsf_pkg::IDX_W'(count_reg - CNT_W'(1));
                                res.rgb       = cmd.rgb;
                                res.finished  = (rows_reg == '0);
                                res.is_last   = 1'b1;
                                drop_next     = cmd.rgb;
                                done_next     = (rows_reg == '0);
                            end
                            else
                            begin
                                res.led_index = lwsf_pkg::IDX_W'(count_reg - CNT_W'(1) - fall_reg);
                                res.rgb       = drop_reg;
                                res.finished  = done_reg;
                                res.is_last   = 1'b0;
                                idx_next      = count_reg - fall_reg;
                                state_next    = lwsf_pkg::BS_MOVE;
                            end
                            if (fall_inc > rows_reg)
                            begin
                                fall_next = '0;
                                if (rows_reg != '0)
                                begin
                                    rows_next = rows_reg - CNT_W'(1);
                                end
                            end
                            else
                            begin
                                fall_next = fall_inc;
                            end
                        end
                    end
                end
            end
            lwsf_pkg::BS_CLEAR:
            begin
                if (!res_full)
                begin
                    res_push      = 1'b1;
                    res.led_index = lwsf_pkg::IDX_W'(idx_reg);
                    res.rgb       = clear_last ? drop_reg : '0;
                    res.finished  = 1'b0;
                    res.is_last   = clear_last;
                    idx_next      = idx_reg + CNT_W'(1);
                    if (clear_last)
                    begin
                        state_next = lwsf_pkg::BS_IDLE;
                    end
                end
            end
            lwsf_pkg::BS_MOVE:
            begin
                if (!res_full)
                begin
                    res_push      = 1'b1;
                    res.led_index = lwsf_pkg::IDX_W'(idx_reg);
                    res.rgb       = '0;
                    res.finished  = done_reg;
                    res.is_last   = 1'b1;
                    state_next    = lwsf_pkg::BS_IDLE;
                end
            end
            default:
            begin
                state_next = lwsf_pkg::BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lwsf_pkg::BS_IDLE;
            count_reg <= CNT_W'(RESET_N);
            acc_reg   <= '0;
            rows_reg  <= CNT_W'(RESET_N - 1);
            fall_reg  <= CNT_W'(1);
            drop_reg  <= '0;
            done_reg  <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            acc_reg   <= acc_next;
            rows_reg  <= rows_next;
            fall_reg  <= fall_next;
            drop_reg  <= drop_next;
            done_reg  <= done_next;
            idx_reg   <= idx_next;
        end
    end

    chk_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("write issued into a full result queue");

    chk_done_settled: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ((fall_reg == '0) && (rows_reg == '0)))
        else $error("strip full but drop still moving");

    chk_clear_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lwsf_pkg::BS_CLEAR) |-> (idx_reg < count_reg))
        else $error("clear index ran past the strip");

endmodule

### rtl/core/led_waterfall_stack_fill_top.sv
// Top level of the LED waterfall stack-fill engine.
//
//  channel   direction  handshake          payload
//  request   in         push / full        operation, delta_ms, period_ms, color_*
//  result    out        empty / pop        led_index, led_red/green/blue, finished, is_last
//  config    in         cfg_write          cfg_data (LED count)
//
// A tick holds full high while the divider forms the quotient, the front end sees it finish
// and writes the request queue; its up to two writes reach the result ports through the request
// queue, back end and result queue. A restart holds full until it enters the request queue.
// The back end then issues one LED write each cycle while the result queue has room.
// The front end divides the next tick while the back end still issues writes.
// Reset is asynchronous; no clearing pass follows it.
// A stalled result side fills the result queue and then the request queue, raising full.
module led_waterfall_stack_fill_top #(
    parameter int MAX_LEDS = lwsf_pkg::MAX_LEDS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [lwsf_pkg::LED_COUNT_W-1:0]    cfg_data,
    input  logic                                push,
    output logic                                full,
    input  logic                                operation,
    input  logic [lwsf_pkg::MS_W-1:0]           delta_ms,
    input  logic [lwsf_pkg::MS_W-1:0]           period_ms,
    input  logic [lwsf_pkg::COLOR_W-1:0]        color_red,
    input  logic [lwsf_pkg::COLOR_W-1:0]        color_green,
    input  logic [lwsf_pkg::COLOR_W-1:0]        color_blue,
    output logic                                empty,
    input  logic                                pop,
    output logic [lwsf_pkg::IDX_W-1:0]          led_index,
    output logic [lwsf_pkg::COLOR_W-1:0]        led_red,
    output logic [lwsf_pkg::COLOR_W-1:0]        led_green,
    output logic [lwsf_pkg::COLOR_W-1:0]        led_blue,
    output logic                                finished,
    output logic                                is_last
);

    localparam int CNT_W = $clog2(MAX_LEDS + 1);
    localparam int CMD_W = $bits(lwsf_pkg::cmd_t);
    localparam int Q_W   = CMD_W + CNT_W;
    localparam int RES_W = $bits(lwsf_pkg::res_t);

    lwsf_pkg::cmd_t    front_cmd;
    logic [CNT_W-1:0]  front_count;
    logic              cmd_push;
    logic              cmd_full;
    logic              cmd_empty;
    logic              cmd_pop;
    logic [Q_W-1:0]    cmd_q_data;
    lwsf_pkg::cmd_t    back_cmd;
    logic [CNT_W-1:0]  back_count;
    logic              res_push;
    logic              res_full;
    lwsf_pkg::res_t    back_res;
    logic [RES_W-1:0]  res_q_data;
    lwsf_pkg::res_t    out_res;

    lwsf_front #(
        .MAX_LEDS (MAX_LEDS),
        .CNT_W    (CNT_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .push       (push),
        .full       (full),
        .operation  (operation),
        .delta_ms   (delta_ms),
        .period_ms  (period_ms),
        .rgb        ({color_red, color_green, color_blue}),
        .cmd_push   (cmd_push),
        .cmd_full   (cmd_full),
        .cmd        (front_cmd),
        .cmd_count  (front_count)
    );

    lwsf_fifo #(
        .WIDTH (Q_W),
        .DEPTH (lwsf_pkg::CMD_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data ({front_cmd, front_count}),
        .rd_en   (cmd_pop),
        .rd_data (cmd_q_data),
        .full    (cmd_full),
        .empty   (cmd_empty)
    );

    assign back_cmd   = lwsf_pkg::cmd_t'(cmd_q_data[CNT_W +: CMD_W]);
    assign back_count = cmd_q_data[CNT_W-1:0];

    lwsf_back #(
        .MAX_LEDS (MAX_LEDS),
        .CNT_W    (CNT_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (back_cmd),
        .cmd_count (back_count),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (back_res)
    );

    lwsf_fifo #(
        .WIDTH (RES_W),
        .DEPTH (lwsf_pkg::RES_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (back_res),
        .rd_en   (pop),
        .rd_data (res_q_data),
        .full    (res_full),
        .empty   (empty)
    );

    assign out_res   = lwsf_pkg::res_t'(res_q_data);
    assign led_index = out_res.led_index;
    assign led_red   = out_res.rgb[2*lwsf_pkg::COLOR_W +: lwsf_pkg::COLOR_W];
    assign led_green = out_res.rgb[lwsf_pkg::COLOR_W +: lwsf_pkg::COLOR_W];
    assign led_blue  = out_res.rgb[0 +: lwsf_pkg::COLOR_W];
    assign finished  = out_res.finished;
    assign is_last   = out_res.is_last;

endmodule

### bench/led_waterfall_stack_fill_checker.sv
// Checker for the LED waterfall stack-fill engine: predicts LED writes and compares them.
`timescale 1ns / 100ps

module led_waterfall_stack_fill_checker #(
    parameter int MAX_LEDS = lwsf_pkg::MAX_LEDS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [lwsf_pkg::LED_COUNT_W-1:0]    cfg_data,
    input  logic                                push,
    input  logic                                full,
    input  logic                                operation,
    input  logic [lwsf_pkg::MS_W-1:0]           delta_ms,
    input  logic [lwsf_pkg::MS_W-1:0]           period_ms,
    input  logic [lwsf_pkg::COLOR_W-1:0]        color_red,
    input  logic [lwsf_pkg::COLOR_W-1:0]        color_green,
    input  logic [lwsf_pkg::COLOR_W-1:0]        color_blue,
    input  logic                                empty,
    input  logic                                pop,
    input  logic [lwsf_pkg::IDX_W-1:0]          led_index,
    input  logic [lwsf_pkg::COLOR_W-1:0]        led_red,
    input  logic [lwsf_pkg::COLOR_W-1:0]        led_green,
    input  logic [lwsf_pkg::COLOR_W-1:0]        led_blue,
    input  logic                                finished,
    input  logic                                is_last,
    output int                                  fail_count,
    output int                                  pending
);

    typedef struct
    {
        logic [lwsf_pkg::IDX_W-1:0]     led_index;
        logic [lwsf_pkg::COLOR_W-1:0]   red;
        logic [lwsf_pkg::COLOR_W-1:0]   green;
        logic [lwsf_pkg::COLOR_W-1:0]   blue;
        logic                           finished;
        logic                           is_last;
    } led_write_t;

    led_write_t                         led_writes_q[$];
    led_write_t                         got;
    led_write_t                         want;
    int                                 mismatches;

    logic [lwsf_pkg::LED_COUNT_W-1:0]   count_reg;
    int unsigned                        strip_len;
    logic [lwsf_pkg::ACC_W-1:0]         elapsed_acc;
    logic [lwsf_pkg::IDX_W-1:0]         rows_left;
    logic [lwsf_pkg::LED_COUNT_W-1:0]   drop_offset;
    logic [lwsf_pkg::RGB_W-1:0]         drop_rgb;
    logic                               strip_full;

    function automatic led_write_t make_write(input int unsigned idx,
                                              input logic [lwsf_pkg::RGB_W-1:0] rgb);
        led_write_t w;
        w.led_index = lwsf_pkg::IDX_W'(idx);
        w.red       = rgb[23:16];
        w.green     = rgb[15:8];
        w.blue      = rgb[7:0];
        w.finished  = 1'b0;
        w.is_last   = 1'b0;
        return w;
    endfunction

    task automatic restart_strip(input logic [lwsf_pkg::RGB_W-1:0] rgb);
        strip_len   = (count_reg < 2) ? 2 : ((count_reg > MAX_LEDS) ? MAX_LEDS : count_reg);
        elapsed_acc = '0;
        rows_left   = lwsf_pkg::IDX_W'(strip_len - 1);
        drop_offset = lwsf_pkg::LED_COUNT_W'(1);
        drop_rgb    = rgb;
        strip_full  = 1'b0;
    endtask

    task automatic predict_request(input lwsf_pkg::op_t op,
                                   input logic [lwsf_pkg::MS_W-1:0] elapsed,
                                   input logic [lwsf_pkg::MS_W-1:0] period,
                                   input logic [lwsf_pkg::RGB_W-1:0] rgb);
        int unsigned    tri_total;
        int unsigned    step_time;
        int unsigned    acc_sum;
        int unsigned    k;
        led_write_t     first_w;
        led_write_t     second_w;
        bit             moving;
        if (op == lwsf_pkg::OP_RESTART)
        begin
            restart_strip(rgb);
            for (k = 0; k < strip_len; k++)
            begin
                first_w = make_write(k, (k == strip_len - 1) ? rgb : '0);
                first_w.is_last = (k == strip_len - 1);
                led_writes_q.push_back(first_w);
            end
        end
        else if (!strip_full)
        begin
            tri_total = (strip_len * (strip_len + 1)) / 2;
            step_time = period / tri_total;
            acc_sum   = elapsed_acc + elapsed;
            elapsed_acc = (acc_sum > lwsf_pkg::ACC_MAX) ? lwsf_pkg::ACC_MAX
                                                         : lwsf_pkg::ACC_W'(acc_sum);
            if (elapsed_acc >= step_time)
            begin
                elapsed_acc = '0;
                moving = (drop_offset != 0);
                if (!moving)
                begin
                    drop_rgb = rgb;
                    first_w  = make_write(strip_len - 1, rgb);
                    if (rows_left == 0)
                    begin
                        strip_full = 1'b1;
                    end
                end
                else
                begin
                    first_w  = make_write(strip_len - 1 - drop_offset, drop_rgb);
                    second_w = make_write(strip_len - drop_offset, '0);
                end
                drop_offset++;
                if (drop_offset > rows_left)
                begin
                    drop_offset = '0;
                    if (rows_left != 0)
                    begin
                        rows_left--;
                    end
                end
                first_w.finished  = strip_full;
                second_w.finished = strip_full;
                if (moving)
                begin
                    second_w.is_last = 1'b1;
                    led_writes_q.push_back(first_w);
                    led_writes_q.push_back(second_w);
                end
                else
                begin
                    first_w.is_last = 1'b1;
                    led_writes_q.push_back(first_w);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_writes_q.delete();
            mismatches = 0;
            count_reg  = lwsf_pkg::LED_COUNT_W'(lwsf_pkg::LED_COUNT_RESET);
            restart_strip('0);
        end
        else
        begin
            if (pop && !empty)
            begin
                got.led_index = led_index;
                got.red       = led_red;
                got.green     = led_green;
                got.blue      = led_blue;
                got.finished  = finished;
                got.is_last   = is_last;
                if (led_writes_q.size() == 0)
                begin
                    $error("LED write to led_index %0d with no request waiting", led_index);
                    mismatches++;
                end
                else
                begin
                    want = led_writes_q.pop_front();
                    if (got.led_index !== want.led_index)
                    begin
                        $error("led_index expected %0d actual %0d", want.led_index, got.led_index);
                        mismatches++;
                    end
                    if (got.red !== want.red)
                    begin
                        $error("led_red expected %0d actual %0d", want.red, got.red);
                        mismatches++;
                    end
                    if (got.green !== want.green)
                    begin
                        $error("led_green expected %0d actual %0d", want.green, got.green);
                        mismatches++;
                    end
                    if (got.blue !== want.blue)
                    begin
                        $error("led_blue expected %0d actual %0d", want.blue, got.blue);
                        mismatches++;
                    end
                    if (got.finished !== want.finished)
                    begin
                        $error("finished expected %0d actual %0d", want.finished, got.finished);
                        mismatches++;
                    end
                    if (got.is_last !== want.is_last)
                    begin
                        $error("is_last expected %0d actual %0d", want.is_last, got.is_last);
                        mismatches++;
                    end
                end
            end
            if (cfg_write)
            begin
                count_reg = cfg_data;
            end
            if (push && !full)
            begin
                predict_request(lwsf_pkg::op_t'(operation), delta_ms, period_ms,
                                {color_red, color_green, color_blue});
            end
        end
        fail_count <= mismatches;
        pending    <= led_writes_q.size();
    end

endmodule

### bench/tb.sv
// Testbench top for the LED waterfall stack-fill engine: stimulus, idling and verdict.
`timescale 1ns / 100ps

module tb;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 6;
    localparam int RANDOM_ITEMS  = 470;
    localparam int MAX_SEQ_TICKS = 40;
    localparam int REST_CYCLES   = 64;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 5000;

    logic                               clk;
    logic                               rst_n;
    logic                               cfg_write;
    logic [lwsf_pkg::LED_COUNT_W-1:0]   cfg_data;
    logic                               push;
    logic                               full;
    logic                               operation;
    logic [lwsf_pkg::MS_W-1:0]          delta_ms;
    logic [lwsf_pkg::MS_W-1:0]          period_ms;
    logic [lwsf_pkg::COLOR_W-1:0]       color_red;
    logic [lwsf_pkg::COLOR_W-1:0]       color_green;
    logic [lwsf_pkg::COLOR_W-1:0]       color_blue;
    logic                               empty;
    logic                               pop;
    logic [lwsf_pkg::IDX_W-1:0]         led_index;
    logic [lwsf_pkg::COLOR_W-1:0]       led_red;
    logic [lwsf_pkg::COLOR_W-1:0]       led_green;
    logic [lwsf_pkg::COLOR_W-1:0]       led_blue;
    logic                               finished;
    logic                               is_last;

    int                                 fail_count;
    int                                 pending;
    int                                 requests_sent;
    int                                 send_idle_pct;
    int                                 recv_idle_pct;
    int                                 quiet_cycles;
    bit                                 hold_pops;

    led_waterfall_stack_fill_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .push        (push),
        .full        (full),
        .operation   (operation),
        .delta_ms    (delta_ms),
        .period_ms   (period_ms),
        .color_red   (color_red),
        .color_green (color_green),
        .color_blue  (color_blue),
        .empty       (empty),
        .pop         (pop),
        .led_index   (led_index),
        .led_red     (led_red),
        .led_green   (led_green),
        .led_blue    (led_blue),
        .finished    (finished),
        .is_last     (is_last)
    );

    led_waterfall_stack_fill_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .push        (push),
        .full        (full),
        .operation   (operation),
        .delta_ms    (delta_ms),
        .period_ms   (period_ms),
        .color_red   (color_red),
        .color_green (color_green),
        .color_blue  (color_blue),
        .empty       (empty),
        .pop         (pop),
        .led_index   (led_index),
        .led_red     (led_red),
        .led_green   (led_green),
        .led_blue    (led_blue),
        .finished    (finished),
        .is_last     (is_last),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_request(input lwsf_pkg::op_t op,
                                input logic [lwsf_pkg::MS_W-1:0] elapsed,
                                input logic [lwsf_pkg::MS_W-1:0] period,
                                input logic [lwsf_pkg::COLOR_W-1:0] red,
                                input logic [lwsf_pkg::COLOR_W-1:0] green,
                                input logic [lwsf_pkg::COLOR_W-1:0] blue);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push        <= 1'b1;
        operation   <= op;
        delta_ms    <= elapsed;
        period_ms   <= period;
        color_red   <= red;
        color_green <= green;
        color_blue  <= blue;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        requests_sent++;
    endtask

    task automatic drain_and_rest();
        @(negedge clk);
        push <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (REST_CYCLES) @(negedge clk);
    endtask

    task automatic set_led_count(input logic [lwsf_pkg::LED_COUNT_W-1:0] value);
        drain_and_rest();
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic send_random_tick(input bit short_period);
        logic [lwsf_pkg::MS_W-1:0] elapsed;
        logic [lwsf_pkg::MS_W-1:0] period;
        if (short_period)
        begin
            period  = 16'($urandom_range(0, 2));
            elapsed = 16'($urandom_range(0, 65535));
        end
        else
        begin
            period  = 16'($urandom_range(0, 65535));
            elapsed = $urandom_range(0, 1) ? 16'($urandom_range(0, 200))
                                           : 16'($urandom_range(0, 65535));
        end
        send_request(lwsf_pkg::OP_TICK, elapsed, period, 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    task automatic run_fill_sequence(input int unsigned strip_len);
        int unsigned    ticks;
        int unsigned    k;
        int unsigned    pick;
        ticks = (strip_len * (strip_len + 1)) / 2 + $urandom_range(0, 3);
        if (ticks > MAX_SEQ_TICKS)
        begin
            ticks = MAX_SEQ_TICKS;
        end
        send_request(lwsf_pkg::OP_RESTART, 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        for (k = 0; k < ticks; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 4)
            begin
                send_request(lwsf_pkg::OP_RESTART, 16'($urandom_range(0, 65535)),
                             16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end
            else
            begin
                send_random_tick(pick < 80);
            end
        end
    endtask

    initial
    begin
        int                                 i;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_pops)
            begin
                pop <= 1'b0;
                for (i = 0; i < HOLD_CYCLES; i++)
                begin
                    @(negedge clk);
                end
                hold_pops = 1'b0;
            end
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        int                                 i;
        int                                 seq_no;
        int unsigned                        pick;
        logic [lwsf_pkg::LED_COUNT_W-1:0]   count_value;
        logic [lwsf_pkg::LED_COUNT_W-1:0]   edge_counts[4];
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_data      = lwsf_pkg::LED_COUNT_W'(lwsf_pkg::LED_COUNT_RESET);
        push          = 1'b0;
        operation     = lwsf_pkg::OP_TICK;
        delta_ms      = '0;
        period_ms     = '0;
        color_red     = '0;
        color_green   = '0;
        color_blue    = '0;
        requests_sent = 0;
        send_idle_pct = 11;
        recv_idle_pct = 72;
        quiet_cycles  = 0;
        hold_pops     = 1'b0;
        edge_counts   = '{7'd127, 7'd1, 7'd64, 7'd2};
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // full strip straight out of reset, then timed steps against a long period
        send_request(lwsf_pkg::OP_TICK, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00);
        send_request(lwsf_pkg::OP_RESTART, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
        send_request(lwsf_pkg::OP_TICK, 16'h0000, 16'hFFFF, 8'h11, 8'h22, 8'h33);
        send_request(lwsf_pkg::OP_TICK, 16'd30, 16'hFFFF, 8'h44, 8'h55, 8'h66);
        send_request(lwsf_pkg::OP_TICK, 16'd1, 16'hFFFF, 8'h77, 8'h88, 8'h99);
        send_request(lwsf_pkg::OP_TICK, 16'hFFFF, 16'hFFFF, 8'h00, 8'h00, 8'h00);

        // count below range, fill to done, ticks after done
        set_led_count(lwsf_pkg::LED_COUNT_W'(0));
        send_request(lwsf_pkg::OP_RESTART, 16'h0000, 16'h0000, 8'h12, 8'h34, 8'h56);
        send_request(lwsf_pkg::OP_TICK, 16'h0000, 16'd2, 8'hA5, 8'hA5, 8'hA5);
        send_request(lwsf_pkg::OP_TICK, 16'h0000, 16'h0000, 8'h5A, 8'h5A, 8'h5A);
        send_request(lwsf_pkg::OP_TICK, 16'h0000, 16'h0000, 8'hFF, 8'h00, 8'hFF);
        send_request(lwsf_pkg::OP_TICK, 16'hFFFF, 16'hFFFF, 8'h00, 8'hFF, 8'h00);
        send_request(lwsf_pkg::OP_RESTART, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00);

        set_led_count(lwsf_pkg::LED_COUNT_W'(3));
        send_request(lwsf_pkg::OP_RESTART, 16'h0000, 16'h0000, 8'h80, 8'h01, 8'h7F);
        for (i = 0; i < 7; i++)
        begin
            send_request(lwsf_pkg::OP_TICK, 16'h0000, 16'h0005, 8'hC0 + 8'(i), 8'h0F, 8'hF0);
        end

        seq_no = 0;
        while (requests_sent < RANDOM_ITEMS)
        begin
            if (requests_sent < 160)
            begin
                send_idle_pct = 11;
                recv_idle_pct = 72;
            end
            else if (requests_sent < 320)
            begin
                send_idle_pct = 72;
                recv_idle_pct = 11;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (seq_no < 4)
            begin
                count_value = edge_counts[seq_no];
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                begin
                    count_value = lwsf_pkg::LED_COUNT_W'($urandom_range(2, 8));
                end
                else if (pick < 85)
                begin
                    count_value = lwsf_pkg::LED_COUNT_W'($urandom_range(9, 64));
                end
                else if (pick < 92)
                begin
                    count_value = lwsf_pkg::LED_COUNT_W'($urandom_range(0, 1));
                end
                else
                begin
                    count_value = lwsf_pkg::LED_COUNT_W'($urandom_range(65, 127));
                end
            end
            set_led_count(count_value);
            if (seq_no == 0)
            begin
                hold_pops = 1'b1;
            end
            run_fill_sequence((count_value < 2) ? 2 : ((count_value > 64) ? 64 : count_value));
            seq_no++;
        end

        drain_and_rest();
        if (fail_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### led_waterfall_stack_fill_top.f
rtl/core/lwsf_pkg.sv
rtl/core/lwsf_fifo.sv
rtl/core/lwsf_div.sv
rtl/core/lwsf_front.sv
rtl/core/lwsf_back.sv
rtl/core/led_waterfall_stack_fill_top.sv
bench/led_waterfall_stack_fill_checker.sv
bench/tb.sv
